/* hw/rtl/fstop_exposure_timer_calc_top_macros.svh */
// Assertion macros used by the f-stop exposure timer checker.
`ifndef FSTOP_EXPOSURE_TIMER_CALC_TOP_MACROS_SVH
`define FSTOP_EXPOSURE_TIMER_CALC_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define FSTOP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define FSTOP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/fstop_pkg.sv */
// Shared types, constants and the fraction table function of the f-stop exposure timer.
package fstop_pkg;

    // Field widths of the input event and the result.
    localparam int CMD_W     = 3;
    localparam int MODE_W    = 3;
    localparam int EXPO_W    = 32;
    localparam int BASE_W    = 17;
    localparam int INDEX_W   = 6;
    localparam int DIVR_W    = 5;
    localparam int COUNT_W   = 5;
    localparam int STRIP_W   = 16;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 88;

    // Reset values, step sizes and upper limits of the settings.
    localparam logic [BASE_W-1:0]         BASE_RESET      = 17'd5000;
    localparam logic [BASE_W-1:0]         BASE_MAX        = 17'd99900;
    localparam logic [BASE_W-1:0]         BASE_SEC_STEP   = 17'd1000;
    localparam logic [BASE_W-1:0]         BASE_TENTH_STEP = 17'd100;
    localparam logic signed [INDEX_W-1:0] INDEX_RESET     = 6'sd1;
    localparam logic [DIVR_W-1:0]         DIVR_RESET      = 5'd3;
    localparam logic [COUNT_W-1:0]        COUNT_RESET     = 5'd6;
    localparam logic [STRIP_W-1:0]        STRIP_RESET     = 16'd2000;
    localparam logic [STRIP_W-1:0]        STRIP_MAX       = 16'd50000;
    localparam logic [STRIP_W-1:0]        STRIP_STEP      = 16'd100;

    // Exponent divider: one quotient bit per cycle.
    localparam int DIV_STEPS = DIVR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Sizing of the elaboration-time root search.
    localparam int FRAC_MAX = 24;
    localparam int M_MAX_W  = FRAC_MAX + 1;
    localparam int BIG_W    = 800;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE       = 3'd0,
        CMD_BASE_SEC   = 3'd1,
        CMD_BASE_TENTH = 3'd2,
        CMD_INDEX      = 3'd3,
        CMD_DIVISOR    = 3'd4,
        CMD_STRIP_MS   = 3'd5,
        CMD_STRIP_CNT  = 3'd6
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR   = 3'd0,
        MODE_GEO      = 3'd1,
        MODE_LIN_TEST = 3'd2,
        MODE_GEO_TEST = 3'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SETUP,
        ST_DIVIDE,
        ST_LOOKUP,
        ST_MULTIPLY,
        ST_SHIFT,
        ST_DELIVER
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply;
        logic setup;
        logic lookup;
        logic multiply;
        logic shift;
        logic deliver;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_idle;
    } dp_status_t;

    // Largest m with m^d <= 2^(r + fb*d), i.e. floor(2^fb * 2^(r/d)), exact.
    function automatic logic [M_MAX_W-1:0] frac_root(input int r, input int d, input int fb);
        logic [BIG_W-1:0]   acc;
        logic [BIG_W-1:0]   lim;
        logic [M_MAX_W-1:0] m;
        logic [M_MAX_W-1:0] c;
        int                 b;
        int                 i;
        m   = M_MAX_W'(1) << fb;
        lim = BIG_W'(1) << (r + fb * d);
        for (b = M_MAX_W - 2; b >= 0; b = b - 1) begin
            if (b < fb) begin
                c   = m | (M_MAX_W'(1) << b);
                acc = BIG_W'(1);
                for (i = 0; i < d; i = i + 1) begin
                    acc = acc * BIG_W'(c);
                end
                if (acc <= lim) begin
                    m = c;
                end
            end
        end
        return m;
    endfunction

endpackage

/* hw/rtl/fstop_div.sv */
// Restoring divider that splits the stop exponent into floor quotient and remainder.
module fstop_div import fstop_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [INDEX_W-1:0] dividend,
    input  logic [DIVR_W-1:0]         divisor,
    output logic signed [INDEX_W-1:0] quotient,
    output logic [DIVR_W-1:0]         remainder,
    output logic                      idle
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DIVR_W-1:0]    quo_reg;
    logic [DIVR_W-1:0]    quo_next;
    logic [DIVR_W-1:0]    rem_reg;
    logic [DIVR_W-1:0]    rem_next;
    logic [DIVR_W-1:0]    den_reg;
    logic                 neg_reg;
    logic [INDEX_W-1:0]   mag;
    logic [DIVR_W:0]      partial;
    logic [DIVR_W+1:0]    diff;
    logic                 fix;
    logic [INDEX_W-1:0]   q_mag;

    // Magnitude of the signed exponent.
    assign mag = dividend[INDEX_W-1] ? INDEX_W'(-dividend) : INDEX_W'(dividend);

    // One trial subtraction per cycle.
    assign partial = {rem_reg, quo_reg[DIVR_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, den_reg};

    always_comb begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start) begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            quo_next = mag[DIVR_W-1:0];
            rem_next = '0;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[DIVR_W+1]) begin
                rem_next = diff[DIVR_W-1:0];
                quo_next = {quo_reg[DIVR_W-2:0], 1'b1};
            end else begin
                rem_next = partial[DIVR_W-1:0];
                quo_next = {quo_reg[DIVR_W-2:0], 1'b0};
            end
        end
    end

    // Step counter is control state; operands are payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= divisor;
            neg_reg <= dividend[INDEX_W-1];
        end
    end

    // A negative exponent with a remainder rounds the quotient toward minus infinity.
    assign fix       = neg_reg && (rem_reg != '0);
    assign q_mag     = {1'b0, quo_reg} + INDEX_W'(fix);
    assign quotient  = neg_reg ? $signed(-q_mag) : $signed(q_mag);
    assign remainder = fix ? (den_reg - rem_reg) : rem_reg;
    assign idle      = (cnt_reg == '0);

endmodule

/* hw/rtl/fstop_dp.sv */
// Datapath: settings registers, exponent split, fraction ROM, multiplier and scaling shift.
module fstop_dp import fstop_pkg::*; #(
    parameter int MAX_STEPS = 24,
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ctrl_cmd_t                 cmd,
    output dp_status_t                status,
    input  logic [CMD_W-1:0]          command,
    input  logic                      step_up,
    input  logic                      step_down,
    input  logic [MODE_W-1:0]         mode,
    output logic [EXPO_W-1:0]         exposure_ms,
    output logic [BASE_W-1:0]         base_ms,
    output logic signed [INDEX_W-1:0] stop_index,
    output logic [DIVR_W-1:0]         stop_divisor,
    output logic [COUNT_W-1:0]        strip_total,
    output logic [STRIP_W-1:0]        strip_ms
);

    localparam int STEP_W = BASE_W + 1;
    localparam int M_W    = FRAC_BITS + 1;
    localparam int PROD_W = BASE_W + M_W;
    localparam int WIDE_W = PROD_W + EXPO_W;
    localparam int SH_W   = 8;
    localparam int LIN_W  = COUNT_W + STRIP_W;
    localparam int ROM_AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int ROM_N  = 1 << ROM_AW;

    localparam logic signed [INDEX_W:0] IDX_HI = (INDEX_W + 1)'(MAX_STEPS);
    localparam logic signed [INDEX_W:0] IDX_LO = -IDX_HI;
    localparam logic signed [SH_W-1:0]  FRAC_S = SH_W'(FRAC_BITS);

    // Up step, then down step with a floor of one, then the upper limit.
    function automatic logic [STEP_W-1:0] step_clamp(
        input logic [STEP_W-1:0] v,
        input logic [STEP_W-1:0] amt,
        input logic [STEP_W-1:0] hi,
        input logic              up,
        input logic              dn
    );
        logic [STEP_W-1:0] t;
        t = v;
        if (up) begin
            t = t + amt;
        end
        if (dn) begin
            t = (t > amt) ? (t - amt) : STEP_W'(1);
        end
        if (t >= hi) begin
            t = hi;
        end
        return t;
    endfunction

    cmd_t                      cmd_reg;
    logic                      up_reg;
    logic                      down_reg;
    mode_t                     mode_reg;

    logic [BASE_W-1:0]         base_reg;
    logic [BASE_W-1:0]         base_next;
    logic signed [INDEX_W-1:0] index_reg;
    logic signed [INDEX_W-1:0] index_next;
    logic [DIVR_W-1:0]         divr_reg;
    logic [DIVR_W-1:0]         divr_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic [STRIP_W-1:0]        strip_reg;
    logic [STRIP_W-1:0]        strip_next;

    logic signed [INDEX_W:0]   idx_t;
    logic [DIVR_W-1:0]         d_eff;
    logic [DIVR_W-1:0]         d_m1;
    logic signed [INDEX_W-1:0] div_dividend;
    logic signed [INDEX_W-1:0] div_q;
    logic [DIVR_W-1:0]         div_r;
    logic                      div_idle;
    logic [LIN_W-1:0]          strip_prod;

    logic [EXPO_W-1:0]         lin_reg;
    logic [M_W-1:0]            frac_reg;
    logic signed [INDEX_W-1:0] q_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [EXPO_W-1:0]         geo_reg;
    logic [EXPO_W-1:0]         geo_next;

    logic signed [SH_W-1:0]    shift_amt;
    logic [SH_W-1:0]           neg_amt;
    logic [WIDE_W-1:0]         wide;
    logic [WIDE_W-1:0]         shifted;
    logic [EXPO_W-1:0]         expo_sel;

    logic [M_W-1:0]            frac_rom [ROM_N][ROM_N];

    logic [EXPO_W-1:0]         exposure_reg;
    logic [BASE_W-1:0]         base_out_reg;
    logic signed [INDEX_W-1:0] index_out_reg;
    logic [DIVR_W-1:0]         divr_out_reg;
    logic [COUNT_W-1:0]        count_out_reg;
    logic [STRIP_W-1:0]        strip_out_reg;

    // Latch the button event when it is transferred in.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg  <= cmd_t'(command);
            up_reg   <= step_up;
            down_reg <= step_down;
            mode_reg <= mode_t'(mode);
        end
    end

    // Stop index steps by one and saturates at the step limit.
    always_comb begin
        idx_t = (INDEX_W + 1)'(index_reg);
        if (up_reg) begin
            idx_t = idx_t + (INDEX_W + 1)'(1);
        end
        if (down_reg) begin
            idx_t = idx_t - (INDEX_W + 1)'(1);
        end
        if (idx_t > IDX_HI) begin
            idx_t = IDX_HI;
        end
        if (idx_t < IDX_LO) begin
            idx_t = IDX_LO;
        end
    end

    // Apply the event to the selected setting.
    always_comb begin
        base_next  = base_reg;
        index_next = index_reg;
        divr_next  = divr_reg;
        count_next = count_reg;
        strip_next = strip_reg;
        if (cmd.apply) begin
            case (cmd_reg)
                CMD_BASE_SEC: begin
                    base_next = BASE_W'(step_clamp(STEP_W'(base_reg), STEP_W'(BASE_SEC_STEP),
                        STEP_W'(BASE_MAX), up_reg, down_reg));
                end
                CMD_BASE_TENTH: begin
                    base_next = BASE_W'(step_clamp(STEP_W'(base_reg), STEP_W'(BASE_TENTH_STEP),
                        STEP_W'(BASE_MAX), up_reg, down_reg));
                end
                CMD_INDEX: begin
                    index_next = idx_t[INDEX_W-1:0];
                end
                CMD_DIVISOR: begin
                    divr_next = DIVR_W'(step_clamp(STEP_W'(divr_reg), STEP_W'(1),
                        STEP_W'(MAX_STEPS), up_reg, down_reg));
                end
                CMD_STRIP_MS: begin
                    strip_next = STRIP_W'(step_clamp(STEP_W'(strip_reg), STEP_W'(STRIP_STEP),
                        STEP_W'(STRIP_MAX), up_reg, down_reg));
                end
                CMD_STRIP_CNT: begin
                    count_next = COUNT_W'(step_clamp(STEP_W'(count_reg), STEP_W'(1),
                        STEP_W'(MAX_STEPS), up_reg, down_reg));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_RESET;
            index_reg <= INDEX_RESET;
            divr_reg  <= DIVR_RESET;
            count_reg <= COUNT_RESET;
            strip_reg <= STRIP_RESET;
        end else begin
            base_reg  <= base_next;
            index_reg <= index_next;
            divr_reg  <= divr_next;
            count_reg <= count_next;
            strip_reg <= strip_next;
        end
    end

    // Exponent and divisor for the geometric modes; a zero divisor acts as one.
    assign d_eff        = (divr_reg == '0) ? DIVR_W'(1) : divr_reg;
    assign d_m1         = d_eff - DIVR_W'(1);
    assign div_dividend = (mode_reg == MODE_GEO_TEST) ? $signed({1'b0, count_reg}) : index_reg;

    fstop_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.setup),
        .dividend  (div_dividend),
        .divisor   (d_eff),
        .quotient  (div_q),
        .remainder (div_r),
        .idle      (div_idle)
    );

    assign status.div_idle = div_idle;

    // Test-strip total is formed while the divider runs.
    assign strip_prod = LIN_W'(count_reg) * LIN_W'(strip_reg);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            lin_reg <= EXPO_W'(base_reg) + EXPO_W'(strip_prod);
        end
    end

    // Fraction ROM: row is divisor minus one, column is remainder.
    for (genvar gr = 0; gr < ROM_N; gr++) begin : g_row
        for (genvar gc = 0; gc < ROM_N; gc++) begin : g_col
            if ((gc <= gr) && (gr < MAX_STEPS)) begin : g_val
                localparam logic [M_W-1:0] ENTRY = M_W'(frac_root(gc, gr + 1, FRAC_BITS));
                assign frac_rom[gr][gc] = ENTRY;
            end else begin : g_zero
                assign frac_rom[gr][gc] = '0;
            end
        end
    end

    // Registered ROM read together with the quotient.
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            frac_reg <= frac_rom[d_m1[ROM_AW-1:0]][div_r[ROM_AW-1:0]];
            q_reg    <= div_q;
        end
    end

    // Base time times the Q-format fraction.
    always_ff @(posedge aclk) begin
        if (cmd.multiply) begin
            prod_reg <= PROD_W'(base_reg) * PROD_W'(frac_reg);
        end
    end

    // Scale by 2^(q - FRAC_BITS), truncating and saturating at 32 bits.
    always_comb begin
        shift_amt = SH_W'(q_reg) - FRAC_S;
        neg_amt   = SH_W'(-shift_amt);
        wide      = WIDE_W'(prod_reg);
        shifted   = '0;
        geo_next  = '0;
        if (shift_amt >= 0) begin
            if (shift_amt >= SH_W'(EXPO_W)) begin
                geo_next = '1;
            end else begin
                shifted  = wide << shift_amt[4:0];
                geo_next = (shifted[WIDE_W-1:EXPO_W] != '0) ? '1 : shifted[EXPO_W-1:0];
            end
        end else begin
            shifted  = wide >> neg_amt;
            geo_next = (shifted[WIDE_W-1:EXPO_W] != '0) ? '1 : shifted[EXPO_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            geo_reg <= geo_next;
        end
    end

    // Exposure for the requested mode.
    always_comb begin
        case (mode_reg)
            MODE_LINEAR:   expo_sel = EXPO_W'(base_reg);
            MODE_GEO:      expo_sel = geo_reg;
            MODE_LIN_TEST: expo_sel = lin_reg;
            MODE_GEO_TEST: expo_sel = geo_reg;
            default:       expo_sel = '0;
        endcase
    end

    // Result register, loaded once the output side is free.
    always_ff @(posedge aclk) begin
        if (cmd.deliver) begin
            exposure_reg  <= expo_sel;
            base_out_reg  <= base_reg;
            index_out_reg <= index_reg;
            divr_out_reg  <= divr_reg;
            count_out_reg <= count_reg;
            strip_out_reg <= strip_reg;
        end
    end

    assign exposure_ms  = exposure_reg;
    assign base_ms      = base_out_reg;
    assign stop_index   = index_out_reg;
    assign stop_divisor = divr_out_reg;
    assign strip_total  = count_out_reg;
    assign strip_ms     = strip_out_reg;

endmodule

/* hw/rtl/fstop_ctrl.sv */
// Controller state machine that sequences one button event through the datapath.
module fstop_ctrl import fstop_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:    state_next = ST_SETUP;
            ST_SETUP:    state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (status.div_idle) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:   state_next = ST_MULTIPLY;
            ST_MULTIPLY: state_next = ST_SHIFT;
            ST_SHIFT:    state_next = ST_DELIVER;
            ST_DELIVER: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_APPLY:    cmd.apply    = 1'b1;
            ST_SETUP:    cmd.setup    = 1'b1;
            ST_DIVIDE: begin
            end
            ST_LOOKUP:   cmd.lookup   = 1'b1;
            ST_MULTIPLY: cmd.multiply = 1'b1;
            ST_SHIFT:    cmd.shift    = 1'b1;
            ST_DELIVER:  cmd.deliver  = out_free;
            default: begin
            end
        endcase
    end

    // Output valid is set on a load and cleared when the result is transferred.
    always_comb begin
        if (cmd.deliver) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

/* hw/rtl/fstop_exposure_timer_calc_top.sv */
// Top level of the f-stop exposure timer: controller, datapath and stream packing.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid / s_tready  s_tdata[7:0]: one button event
//  m_       out        m_tvalid / m_tready  m_tdata[87:0]: exposure and all five settings
//
// An event passes through the apply and setup states, the restoring division of
// the stop exponent and the ROM, multiply and shift stages before its result is
// loaded; the next event is taken only after that.
// Synchronous active-low reset restores the settings to 5000 ms, index 1,
// divisor 3, six strips of 2000 ms; there is no clearing pass.
// A result waiting on m_ does not block the next event; the controller holds only
// in its last state until the output register is free.
module fstop_exposure_timer_calc_top import fstop_pkg::*; #(
    parameter int MAX_STEPS = 24,
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command[2:0], step_up[3], step_down[4], mode[7:5]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // exposure_ms[31:0], base_ms[48:32], stop_index[54:49], stop_divisor[59:55],
    // strip_total[64:60], strip_ms[80:65], zero[87:81]
    output logic [M_TDATA_W-1:0] m_tdata
);

    ctrl_cmd_t                 cmd;
    dp_status_t                status;
    logic [EXPO_W-1:0]         exposure_ms;
    logic [BASE_W-1:0]         base_ms;
    logic signed [INDEX_W-1:0] stop_index;
    logic [DIVR_W-1:0]         stop_divisor;
    logic [COUNT_W-1:0]        strip_total;
    logic [STRIP_W-1:0]        strip_ms;

    fstop_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    fstop_dp #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .command      (s_tdata[2:0]),
        .step_up      (s_tdata[3]),
        .step_down    (s_tdata[4]),
        .mode         (s_tdata[7:5]),
        .exposure_ms  (exposure_ms),
        .base_ms      (base_ms),
        .stop_index   (stop_index),
        .stop_divisor (stop_divisor),
        .strip_total  (strip_total),
        .strip_ms     (strip_ms)
    );

    // Pack the result fields, highest field first.
    assign m_tdata = {7'b0, strip_ms, strip_total, stop_divisor, stop_index, base_ms,
                      exposure_ms};

endmodule

/* hw/rtl/fstop_chk.sv */
// Port-level checker for the f-stop exposure timer and its bind to the top level.
`include "fstop_exposure_timer_calc_top_macros.svh"

module fstop_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    // Reset empties the output register.
    `FSTOP_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    // Events are handled one at a time: a transfer in closes the input side.
    `FSTOP_ASSERT(a_one_event, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "s_tready held after transfer")

    // Reported base and strip times always stay inside their limits; divisor and strip count are never zero.
    `FSTOP_ASSERT(a_settings_range, aclk, aresetn, m_tvalid |-> (m_tdata[48:32] != 17'd0) && (m_tdata[48:32] <= 17'd99900) && (m_tdata[59:55] != 5'd0) && (m_tdata[64:60] != 5'd0) && (m_tdata[80:65] != 16'd0) && (m_tdata[80:65] <= 16'd50000), "setting out of range")

    // A stalled result keeps its payload.
    `FSTOP_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata changed under stall")

endmodule

bind fstop_exposure_timer_calc_top fstop_chk u_chk (.*);
